// ----- src/itoaf_pkg.sv -----
// Shared constants, item types and the helper function of the integer to ASCII formatter.
package itoaf_pkg;

    localparam int MAX_WIDTH  = 20;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int DEC_BITS   = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 16;
    localparam int BCD_BITS   = 4 * DEC_DIGITS;
    localparam int DIG_BITS   = 4 * HEX_DIGITS;
    localparam int CNT_W      = $clog2(DEC_BITS);
    localparam int WID_W      = 5;

    localparam logic       OP_DEC     = 1'b0;
    localparam logic       OP_HEX     = 1'b1;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_A      = 8'h61;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_MINUS  = 8'h2d;
    localparam logic [3:0] RADIX_DEC  = 4'd10;

    typedef struct packed {
        logic        opcode;
        logic [63:0] value;
        logic [4:0]  min_width;
        logic        zero_pad;
    } t_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_result;

    typedef struct packed {
        logic             is_hex;
        logic             neg;
        logic [63:0]      mag;
        logic [WID_W-1:0] width;
        logic             zero_pad;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < RADIX_DEC) begin
            ch = CHR_ZERO + {4'd0, nib};
        end else begin
            ch = CHR_A + {4'd0, nib - RADIX_DEC};
        end
        return ch;
    endfunction

endpackage

// ----- src/itoaf_front.sv -----
// Front end: accepts items, works out sign, magnitude and width, and hands jobs to the queue.
module itoaf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  itoaf_pkg::t_item     i_item,
    input  logic                 i_q_full,
    output logic                 busy,
    output logic                 o_push,
    output itoaf_pkg::t_job      o_job
);
    import itoaf_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_job        r_job;
    t_job        n_job;
    logic        accept;
    logic [31:0] word;
    logic        neg;
    logic [31:0] mag32;

    assign busy   = r_valid && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_valid && !i_q_full;
    assign o_job  = r_job;

    always_comb begin
        word  = i_item.value[31:0];
        neg   = (i_item.opcode == OP_DEC) && word[31];
        mag32 = neg ? (32'd0 - word) : word;
        n_job.is_hex   = (i_item.opcode == OP_HEX);
        n_job.neg      = neg;
        n_job.mag      = (i_item.opcode == OP_HEX) ? i_item.value : {32'd0, mag32};
        n_job.zero_pad = i_item.zero_pad;
        if ({1'b0, i_item.min_width} > 6'(MAX_WIDTH)) begin
            n_job.width = WID_W'(MAX_WIDTH);
        end else begin
            n_job.width = i_item.min_width;
        end
        n_valid = accept || (r_valid && i_q_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// ----- src/itoaf_queue.sv -----
// Short job queue between the front end and the back end.
module itoaf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  itoaf_pkg::t_job  i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output itoaf_pkg::t_job  o_head
);
    import itoaf_pkg::*;

    t_job              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

// ----- src/itoaf_back.sv -----
// Back end: binary to BCD conversion of decimal items, digit count and character emission with padding.
module itoaf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  itoaf_pkg::t_job     i_head,
    output logic                o_pop,
    output logic                o_strobe,
    output itoaf_pkg::t_result  o_result
);
    import itoaf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_COUNT = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [DIG_BITS-1:0] r_dig;
    logic [DIG_BITS-1:0] n_dig;
    logic [DEC_BITS-1:0] r_bin;
    logic [DEC_BITS-1:0] n_bin;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [WID_W-1:0]    r_nd;
    logic [WID_W-1:0]    n_nd;
    logic [WID_W-1:0]    r_c;
    logic [WID_W-1:0]    n_c;
    logic [WID_W-1:0]    r_width;
    logic [WID_W-1:0]    n_width;
    logic                r_neg;
    logic                n_neg;
    logic                r_zpad;
    logic                n_zpad;
    logic                r_first;
    logic                n_first;
    logic                r_strobe;
    logic                n_strobe;
    t_result             r_result;
    t_result             n_result;
    logic [BCD_BITS-1:0] adj;
    logic [3:0]          nib;
    logic [WID_W-1:0]    nd;
    logic [WID_W-1:0]    body;
    logic [3:0]          cur;

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            nib = r_dig[4*i +: 4];
            adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
        nd = WID_W'(1);
        for (int i = 1; i < HEX_DIGITS; i++) begin
            if (r_dig[4*i +: 4] != 4'd0) begin
                nd = WID_W'(i + 1);
            end
        end
        body = nd + {{(WID_W-1){1'b0}}, r_neg};
        cur  = r_dig[{r_c[3:0], 2'b00} +: 4];
    end

    always_comb begin
        n_state  = r_state;
        n_dig    = r_dig;
        n_bin    = r_bin;
        n_cnt    = r_cnt;
        n_nd     = r_nd;
        n_c      = r_c;
        n_width  = r_width;
        n_neg    = r_neg;
        n_zpad   = r_zpad;
        n_first  = r_first;
        n_strobe = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_neg   = i_head.neg;
                    n_zpad  = i_head.zero_pad;
                    n_width = i_head.width;
                    n_cnt   = '0;
                    if (i_head.is_hex) begin
                        n_dig   = i_head.mag;
                        n_state = ST_COUNT;
                    end else begin
                        n_dig   = '0;
                        n_bin   = i_head.mag[DEC_BITS-1:0];
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_dig = {{(DIG_BITS-BCD_BITS){1'b0}}, adj[BCD_BITS-2:0], r_bin[DEC_BITS-1]};
                n_bin = {r_bin[DEC_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DEC_BITS - 1)) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                n_nd    = nd;
                n_c     = ((r_width > body) ? r_width : body) - 1'b1;
                n_first = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_first  = 1'b0;
                if (r_c < r_nd) begin
                    n_result.character = hex_char(cur);
                end else if (r_neg && ((r_zpad && r_first) || (!r_zpad && r_c == r_nd))) begin
                    n_result.character = CHR_MINUS;
                end else begin
                    n_result.character = r_zpad ? CHR_ZERO : CHR_SPACE;
                end
                n_result.last = (r_c == '0);
                if (r_c == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_c = r_c - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_dig    <= n_dig;
        r_bin    <= n_bin;
        r_cnt    <= n_cnt;
        r_nd     <= n_nd;
        r_c      <= n_c;
        r_width  <= n_width;
        r_neg    <= n_neg;
        r_zpad   <= n_zpad;
        r_first  <= n_first;
        r_result <= n_result;
    end

endmodule

// ----- src/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter: front end, job queue and back end.
//
// An item is taken at a rising edge with start high and busy low. It carries an
// opcode (signed decimal of the low 32 bits, or unsigned hexadecimal of all 64),
// the value, a minimum field width and a zero-pad flag. Each item produces one
// to twenty characters, most significant first, each shown for one cycle with
// o_strobe high; the final one has last set. The receiver cannot stall.
// The front end registers a classified item and passes it to a
// two-entry queue, so up to three items can be held while one is printed.
// The back end converts a decimal item with a binary to BCD shifter that takes
// one bit of the 32-bit magnitude each cycle, then counts the digits and emits
// the characters; a hexadecimal item skips the shifter. The back end takes the
// next item from the queue only after the last character of the current one.
// busy rises only while the queue and the front register are full.
// A synchronous reset empties the queue and drops any item being printed.
module integer_to_ascii_formatter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  itoaf_pkg::t_item    i_item,
    output logic                busy,
    output logic                o_strobe,
    output itoaf_pkg::t_result  o_result
);
    import itoaf_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job job;
    t_job head;

    itoaf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .i_q_full (q_full),
        .busy     (busy),
        .o_push   (push),
        .o_job    (job)
    );

    itoaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    itoaf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

// ----- src/itoaf_checker.sv -----
// Port-level checks on the integer to ASCII formatter, bound to its top level.
module itoaf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                busy,
    input logic                o_strobe,
    input itoaf_pkg::t_result  o_result
);
    import itoaf_pkg::*;

    logic [7:0] ch;

    assign ch = o_result.character;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("strobe or busy seen right after reset");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((ch >= CHR_ZERO && ch <= 8'h39) || (ch >= CHR_A && ch <= 8'h66)
                      || ch == CHR_SPACE || ch == CHR_MINUS))
        else $error("character outside the output alphabet");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_strobe)
        else $error("no idle cycle after the last character of an item");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ch == CHR_MINUS) |-> !o_result.last)
        else $error("minus sign emitted as the last character");

endmodule

bind integer_to_ascii_formatter itoaf_checker u_itoaf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the integer to ASCII formatter, with its own text predictor.
`timescale 1ns / 1ps

module testbench;

    import itoaf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        t_result res;
        int      item_no;
    } t_expected_char;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    t_expected_char expected_chars[$];
    int             error_count = 0;
    int             items_sent  = 0;
    int             idle_cycles = 0;

    integer_to_ascii_formatter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Builds the characters of one item and queues them, most significant first.
    function automatic void format_number(input t_item it, input int item_no);
        logic [7:0]     digits[$];
        logic [7:0]     text[$];
        logic [31:0]    dmag;
        logic [63:0]    hmag;
        logic [3:0]     nib;
        logic           neg;
        int             width;
        int             pad;
        t_expected_char e;
        width = (it.min_width > MAX_WIDTH) ? MAX_WIDTH : int'(it.min_width);
        neg = 1'b0;
        if (it.opcode == OP_DEC) begin
            dmag = it.value[31:0];
            if (dmag[31]) begin
                neg = 1'b1;
                dmag = 32'd0 - dmag;
            end
            do begin
                nib = 4'(dmag % 32'd10);
                digits.push_back(CHR_ZERO + 8'(nib));
                dmag = dmag / 32'd10;
            end while (dmag != 32'd0);
        end else begin
            hmag = it.value;
            do begin
                nib = hmag[3:0];
                digits.push_back((nib < 4'd10) ? CHR_ZERO + 8'(nib) : CHR_A + 8'(nib) - 8'd10);
                hmag = hmag >> 4;
            end while (hmag != 64'd0);
        end
        pad = width - (digits.size() + int'(neg));
        if (pad < 0) begin
            pad = 0;
        end
        if (!it.zero_pad) begin
            repeat (pad) text.push_back(CHR_SPACE);
        end
        if (neg) begin
            text.push_back(CHR_MINUS);
        end
        if (it.zero_pad) begin
            repeat (pad) text.push_back(CHR_ZERO);
        end
        for (int k = digits.size() - 1; k >= 0; k--) begin
            text.push_back(digits[k]);
        end
        for (int k = 0; k < text.size(); k++) begin
            e.res.character = text[k];
            e.res.last = (k == text.size() - 1);
            e.item_no = item_no;
            expected_chars.push_back(e);
        end
    endfunction

    function automatic t_item make_item(input logic op, input logic [63:0] value,
                                        input logic [4:0] width, input logic zpad);
        t_item it;
        it.opcode = op;
        it.value = value;
        it.min_width = width;
        it.zero_pad = zpad;
        return it;
    endfunction

    task automatic send_item(input t_item it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        if (idle_pct != 0 && $urandom_range(15) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(30, 90)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        format_number(it, items_sent);
        items_sent++;
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        logic [31:0] w;
        case ($urandom_range(5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 20));
            2: begin
                w = 32'd0 - 32'($urandom_range(1, 300));
                v = {$urandom, w};
            end
            3: begin
                case ($urandom_range(3))
                    0: w = 32'h8000_0000;
                    1: w = 32'h7FFF_FFFF;
                    2: w = 32'hFFFF_FFFF;
                    default: w = 32'h8000_0001;
                endcase
                v = {$urandom, w};
            end
            4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: begin
                w = 32'd1;
                repeat ($urandom_range(0, 9)) w = w * 32'd10;
                w = w - 32'($urandom_range(0, 1));
                if ($urandom_range(1)) begin
                    w = 32'd0 - w;
                end
                v = {32'($urandom_range(0, 1) ? $urandom : 0), w};
            end
        endcase
        return v;
    endfunction

    task automatic test_decimal_edges();
        send_item(make_item(OP_DEC, 64'd0, 5'd0, 1'b0), 0);
        send_item(make_item(OP_DEC, 64'd7, 5'd0, 1'b0), 0);
        send_item(make_item(OP_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0), 0);
        send_item(make_item(OP_DEC, 64'h0000_0000_7FFF_FFFF, 5'd0, 1'b0), 0);
        send_item(make_item(OP_DEC, 64'h0000_0000_8000_0000, 5'd0, 1'b0), 0);
        send_item(make_item(OP_DEC, 64'hDEAD_BEEF_0000_04D2, 5'd0, 1'b0), 0);
        send_item(make_item(OP_DEC, 64'h0000_0000_8000_0000, 5'd3, 1'b1), 0);
        send_item(make_item(OP_DEC, 64'h1234_5678_3B9A_CA00, 5'd0, 1'b0), 0);
    endtask

    task automatic test_hex_edges();
        send_item(make_item(OP_HEX, 64'd0, 5'd0, 1'b0), 0);
        send_item(make_item(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0), 0);
        send_item(make_item(OP_HEX, 64'h0123_4567_89AB_CDEF, 5'd0, 1'b0), 0);
        send_item(make_item(OP_HEX, 64'hA, 5'd1, 1'b0), 0);
        send_item(make_item(OP_HEX, 64'h8000_0000_0000_0000, 5'd0, 1'b1), 0);
        send_item(make_item(OP_HEX, 64'hFEDC_BA98_7654_3210, 5'd20, 1'b0), 0);
    endtask

    task automatic test_padding();
        send_item(make_item(OP_DEC, 64'hFFFF_FFFF_FFFF_FFD6, 5'd6, 1'b1), 0);
        send_item(make_item(OP_DEC, 64'hFFFF_FFFF_FFFF_FFD6, 5'd6, 1'b0), 0);
        send_item(make_item(OP_DEC, 64'd0, 5'd20, 1'b1), 0);
        send_item(make_item(OP_DEC, 64'd5, 5'd31, 1'b0), 0);
        send_item(make_item(OP_HEX, 64'hBEEF, 5'd31, 1'b1), 0);
        send_item(make_item(OP_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 1'b1), 0);
        send_item(make_item(OP_HEX, 64'h1F, 5'd20, 1'b0), 0);
        send_item(make_item(OP_DEC, 64'd123, 5'd1, 1'b1), 0);
    endtask

    task automatic test_random_items(input int count, input int idle_pct);
        logic [4:0] width;
        for (int n = 0; n < count; n++) begin
            width = ($urandom_range(3) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, 20));
            send_item(make_item(1'($urandom_range(1)), rand_value(), width,
                                1'($urandom_range(1))), idle_pct);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
        end
    endtask

    always @(posedge i_clk) begin
        t_expected_char want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("character %02h with no item outstanding",
                                          o_result.character));
            end else begin
                want = expected_chars.pop_front();
                if (o_result.character !== want.res.character) begin
                    report_mismatch($sformatf("item %0d: character %02h, expected %02h",
                                              want.item_no, o_result.character,
                                              want.res.character));
                end
                if (o_result.last !== want.res.last) begin
                    report_mismatch($sformatf("item %0d: last %b, expected %b",
                                              want.item_no, o_result.last, want.res.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("integer_to_ascii_formatter regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_decimal_edges();
        test_hex_edges();
        test_padding();
        test_random_items(63, 0);
        test_random_items(63, 73);
        test_random_items(63, 22);
        drain();
        if (error_count == 0) begin
            $display("integer_to_ascii_formatter regression: pass");
        end else begin
            $display("integer_to_ascii_formatter regression: fail");
        end
        $finish;
    end

endmodule
